// ===== rtl/core/mbrd_pkg.sv =====
package mbrd_pkg;

    localparam logic [1:0] OP_FOLD    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_LOAD    = 2'd3;

    localparam logic [1:0] CFG_PORTS = 2'd0;
    localparam logic [1:0] CFG_BINS  = 2'd1;
    localparam logic [1:0] CFG_SCALE = 2'd2;

    localparam int INPUT_PORTS = 4;
    localparam int MUL_A_W     = 35;
    localparam int MUL_B_W     = 33;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RND_W       = PROD_W - 30;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [RND_W-1:0]  t_rnd;

    // round to nearest, ties up, then drop 30 fraction bits
    function automatic t_rnd round_q30(input t_prod p);
        t_prod t;
        t = p + 68'sd536870912;
        return $signed(t[PROD_W-1:30]);
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input t_rnd d);
        logic signed [64:0] s;
        s = 65'(a) + 65'(d);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input t_rnd v);
        if (v > 38'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -38'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/core/mbrd_mul.sv =====
module mbrd_mul (
    input  logic                                i_clk,
    input  logic signed [mbrd_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [mbrd_pkg::MUL_B_W-1:0] i_b,
    output mbrd_pkg::t_prod                     o_p
);
    import mbrd_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/multi_bin_running_dft_top.sv =====
// Running DFT bank: per-bin recursive phasors, one accumulator pair per channel and bin.
// Input stream: tuser = opcode (fold, read, restart, load rotation); tdata carries the
// four port samples, source sample, channel select, bin index and rotation pair.
// Output stream: one item per read, tdata = real/imag accumulators, tuser = in-range flag.
// Config: i_cfg_we / i_cfg_addr / i_cfg_data write active_ports, active_bins, scale.
// All products go through one registered 35x33 multiplier under a sequencer, so a fold,
// read or restart holds the block busy (tready low) while it runs:
//   fold:    scales each of the C folded channels (ports + source), then for each of the
//            B active bins updates every channel's accumulators and rotates the phasor.
//   read:    through ST_RA and ST_RD to the output register; load rotation: written on accept.
//   restart: clearing pass over CHANNELS * 2^ceil(log2(BIN_COUNT)) entries (1280 by default),
//            which also runs right after reset; no item is taken meanwhile.
// The read result sits in an output register; a stalled receiver holds it while other
// items keep going, and a following read waits only until that register is free.
// Reset (synchronous, active low) loads the default registers and starts the clear.
module multi_bin_running_dft_top #(
    parameter int BIN_COUNT   = 256,
    parameter int PORT_COUNT  = 4,
    parameter int SAMPLE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [30:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a, b, c, d, source (32 each), channel_select (3), bin_index (8), rot cos, rot sin
    input  logic [239:0] i_s_axis_tdata,
    // opcode
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // spectrum_real (64), spectrum_imag (64)
    output logic [127:0] o_m_axis_tdata,
    // read_in_range
    output logic [0:0]   o_m_axis_tuser
);
    import mbrd_pkg::*;

    localparam int CHANNELS  = PORT_COUNT + 1;
    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int ACC_AW    = CH_W + BIN_W;
    localparam int ACC_DEPTH = CHANNELS << BIN_W;
    localparam int BCNT_W    = $clog2(BIN_COUNT + 1);
    localparam int EB_W      = (BCNT_W > 9) ? BCNT_W : 9;
    localparam int FOLD_LIM  = (PORT_COUNT < INPUT_PORTS) ? PORT_COUNT : INPUT_PORTS;
    localparam logic [31:0] KEEP = {32{1'b1}} << (32 - SAMPLE_BITS);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_SCALE, ST_SCALE_W, ST_BADDR, ST_CA, ST_CB, ST_CC,
        ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_RA, ST_RD
    } t_state;

    t_state r_state;

    logic [2:0]  r_act_ports;
    logic [8:0]  r_act_bins;
    logic [30:0] r_scale;

    logic signed [31:0] r_port [INPUT_PORTS];
    logic signed [31:0] r_src;
    logic signed [MUL_A_W-1:0] r_scaled [CHANNELS];
    logic [CH_W-1:0]   r_ch;
    logic [BIN_W-1:0]  r_m;
    logic [ACC_AW-1:0] r_clr;
    logic              r_ok;
    t_prod             r_p1;
    logic signed [31:0] r_newc;

    logic               r_ovalid;
    logic signed [63:0] r_ore;
    logic signed [63:0] r_oim;
    logic               r_ook;

    // memories
    logic signed [31:0] r_ph_c  [BIN_COUNT];
    logic signed [31:0] r_ph_s  [BIN_COUNT];
    logic signed [31:0] r_rot_c [BIN_COUNT];
    logic signed [31:0] r_rot_s [BIN_COUNT];
    logic signed [63:0] r_acc_re [ACC_DEPTH];
    logic signed [63:0] r_acc_im [ACC_DEPTH];
    logic signed [31:0] r_ph_c_q, r_ph_s_q, r_rot_c_q, r_rot_s_q;
    logic signed [63:0] r_acc_re_q, r_acc_im_q;

    // input fields
    logic [2:0] in_ch;
    logic [7:0] in_bin;
    assign in_ch  = i_s_axis_tdata[162:160];
    assign in_bin = i_s_axis_tdata[170:163];

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // derived limits
    logic [EB_W-1:0] eff_bins;
    logic [2:0]      fold_ports;
    logic [3:0]      read_ports;
    logic [CH_W-1:0] first_ch, ch_next;
    logic            last_ch, last_bin, rd_ok, ld_ok, out_free;

    always_comb begin
        eff_bins   = (EB_W'(r_act_bins) > EB_W'(BIN_COUNT)) ? EB_W'(BIN_COUNT)
                                                             : EB_W'(r_act_bins);
        fold_ports = (r_act_ports > 3'(FOLD_LIM)) ? 3'(FOLD_LIM) : r_act_ports;
        read_ports = (4'(r_act_ports) > 4'(PORT_COUNT)) ? 4'(PORT_COUNT)
                                                        : 4'(r_act_ports);
        first_ch   = (fold_ports == 3'd0) ? CH_W'(PORT_COUNT) : '0;
        // skip from the last folded port straight to the source channel
        ch_next    = (4'(r_ch) + 4'd1 == {1'b0, fold_ports}) ? CH_W'(PORT_COUNT)
                                                             : r_ch + 1'b1;
        last_ch    = (4'(r_ch) == 4'(PORT_COUNT));
        last_bin   = (EB_W'(r_m) + EB_W'(1) == eff_bins);
        rd_ok      = ((4'(in_ch) == 4'(PORT_COUNT)) || (4'(in_ch) < read_ports))
                     && (EB_W'(in_bin) < eff_bins);
        ld_ok      = EB_W'(in_bin) < EB_W'(BIN_COUNT);
        out_free   = !r_ovalid || i_m_axis_tready;
    end

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    t_prod                     prod;
    logic signed [31:0]        sel_sample;

    assign sel_sample = last_ch ? r_src : r_port[2'(r_ch)];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SCALE: begin
                mul_a = MUL_A_W'(sel_sample);
                mul_b = $signed({2'b00, r_scale});
            end
            ST_CA: begin
                mul_a = r_scaled[r_ch];
                mul_b = MUL_B_W'(r_ph_c_q);
            end
            ST_CB: begin
                mul_a = r_scaled[r_ch];
                mul_b = MUL_B_W'(r_ph_s_q);
            end
            ST_R1: begin
                mul_a = MUL_A_W'(r_ph_c_q);
                mul_b = MUL_B_W'(r_rot_c_q);
            end
            ST_R2: begin
                mul_a = MUL_A_W'(r_ph_s_q);
                mul_b = MUL_B_W'(r_rot_s_q);
            end
            ST_R3: begin
                mul_a = MUL_A_W'(r_ph_s_q);
                mul_b = MUL_B_W'(r_rot_c_q);
            end
            ST_R4: begin
                mul_a = MUL_A_W'(r_ph_c_q);
                mul_b = MUL_B_W'(r_rot_s_q);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mbrd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // memory write side
    logic               ph_we, acc_re_we, acc_im_we, rot_we;
    logic [BIN_W-1:0]   ph_wa;
    logic signed [31:0] ph_wc, ph_ws;
    logic [ACC_AW-1:0]  acc_wa, acc_ra;
    logic signed [63:0] acc_re_wd, acc_im_wd;

    assign acc_ra = {r_ch, r_m};
    assign rot_we = s_acc && (i_s_axis_tuser == OP_LOAD) && ld_ok;

    always_comb begin
        ph_we     = 1'b0;
        ph_wa     = r_m;
        ph_wc     = r_newc;
        ph_ws     = sat32(round_q30(r_p1 + prod));
        acc_re_we = 1'b0;
        acc_im_we = 1'b0;
        acc_wa    = acc_ra;
        acc_re_wd = sat_add64(r_acc_re_q, round_q30(prod));
        acc_im_wd = sat_add64(r_acc_im_q, -round_q30(prod));
        case (r_state)
            ST_CLR: begin
                ph_wa     = r_clr[BIN_W-1:0];
                ph_we     = {1'b0, r_clr[BIN_W-1:0]} < (BIN_W+1)'(BIN_COUNT);
                ph_wc     = ONE_Q30;
                ph_ws     = '0;
                acc_wa    = r_clr;
                acc_re_we = 1'b1;
                acc_im_we = 1'b1;
                acc_re_wd = '0;
                acc_im_wd = '0;
            end
            ST_CB:   acc_re_we = 1'b1;
            ST_CC:   acc_im_we = 1'b1;
            ST_R5:   ph_we = 1'b1;
            default: ph_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ph_we) begin
            r_ph_c[ph_wa] <= ph_wc;
            r_ph_s[ph_wa] <= ph_ws;
        end
        r_ph_c_q <= r_ph_c[r_m];
        r_ph_s_q <= r_ph_s[r_m];
    end

    always_ff @(posedge i_clk) begin
        if (rot_we) begin
            r_rot_c[BIN_W'(in_bin)] <= $signed(i_s_axis_tdata[202:171]);
            r_rot_s[BIN_W'(in_bin)] <= $signed(i_s_axis_tdata[234:203]);
        end
        r_rot_c_q <= r_rot_c[r_m];
        r_rot_s_q <= r_rot_s[r_m];
    end

    always_ff @(posedge i_clk) begin
        if (acc_re_we) begin
            r_acc_re[acc_wa] <= acc_re_wd;
        end
        if (acc_im_we) begin
            r_acc_im[acc_wa] <= acc_im_wd;
        end
        r_acc_re_q <= r_acc_re[acc_ra];
        r_acc_im_q <= r_acc_im[acc_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_act_ports <= 3'd0;
            r_act_bins  <= 9'd200;
            r_scale     <= 31'h4000_0000;
            r_ovalid    <= 1'b0;
            r_ch        <= '0;
            r_m         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PORTS: r_act_ports <= i_cfg_data[2:0];
                    CFG_BINS:  r_act_bins  <= i_cfg_data[8:0];
                    CFG_SCALE: r_scale     <= i_cfg_data;
                    default:   r_scale     <= r_scale;
                endcase
            end
            // in ST_RD the valid flag is handled by the state below
            if (r_ovalid && i_m_axis_tready && (r_state != ST_RD)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ACC_AW'(ACC_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        case (i_s_axis_tuser)
                            OP_FOLD: begin
                                for (int p = 0; p < INPUT_PORTS; p++) begin
                                    r_port[p] <= $signed(i_s_axis_tdata[32*p +: 32] & KEEP);
                                end
                                r_src <= $signed(i_s_axis_tdata[159:128] & KEEP);
                                r_ch  <= first_ch;
                                r_m   <= '0;
                                r_state <= (eff_bins == '0) ? ST_IDLE : ST_SCALE;
                            end
                            OP_READ: begin
                                r_ch    <= CH_W'(in_ch);
                                r_m     <= BIN_W'(in_bin);
                                r_ok    <= rd_ok;
                                r_state <= ST_RA;
                            end
                            OP_RESTART: begin
                                r_clr   <= '0;
                                r_state <= ST_CLR;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCALE: r_state <= ST_SCALE_W;
                ST_SCALE_W: begin
                    r_scaled[r_ch] <= MUL_A_W'(round_q30(prod));
                    if (last_ch) begin
                        r_state <= ST_BADDR;
                    end else begin
                        r_ch    <= ch_next;
                        r_state <= ST_SCALE;
                    end
                end
                ST_BADDR: begin
                    r_ch    <= first_ch;
                    r_state <= ST_CA;
                end
                ST_CA: r_state <= ST_CB;
                ST_CB: r_state <= ST_CC;
                ST_CC: begin
                    if (last_ch) begin
                        r_state <= ST_R1;
                    end else begin
                        r_ch    <= ch_next;
                        r_state <= ST_CA;
                    end
                end
                ST_R1: r_state <= ST_R2;
                ST_R2: begin
                    r_p1    <= prod;
                    r_state <= ST_R3;
                end
                ST_R3: begin
                    r_newc  <= sat32(round_q30(r_p1 - prod));
                    r_state <= ST_R4;
                end
                ST_R4: begin
                    r_p1    <= prod;
                    r_state <= ST_R5;
                end
                ST_R5: begin
                    if (last_bin) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= ST_BADDR;
                    end
                end
                ST_RA: r_state <= ST_RD;
                ST_RD: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ore    <= r_ok ? r_acc_re_q : '0;
                        r_oim    <= r_ok ? r_acc_im_q : '0;
                        r_ook    <= r_ok;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready   = (r_state == ST_IDLE);
    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = {r_oim, r_ore};
    assign o_m_axis_tuser[0] = r_ook;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_ook |-> (r_ore == '0) && (r_oim == '0))
        else $error("out-of-range read carries nonzero data");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_axis_tuser == OP_RESTART) |=> (r_state == ST_CLR) && (r_clr == '0))
        else $error("restart did not start clearing pass");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CA) |-> (4'(r_ch) <= 4'(PORT_COUNT)))
        else $error("channel counter out of range");

    a_read_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) && r_ovalid && !i_m_axis_tready |=> $stable(r_ore))
        else $error("pending result overwritten");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import mbrd_pkg::*;

    localparam int BINS  = 256;
    localparam int PORTS = 4;
    localparam int SRC_CH = PORTS;
    localparam logic [1:0] CFG_NONE = 2'd3;   // unmapped register index

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] smp [5];          // ports a..d, then source
        logic [2:0]         chan;
        logic [7:0]         bin;
        logic signed [31:0] rot_c;
        logic signed [31:0] rot_s;
    } t_item;

    typedef struct {
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic               in_range;
    } t_spectrum;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [30:0]  i_cfg_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [239:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;

    multi_bin_running_dft_top dut (.*);

    always #6 i_clk = ~i_clk;

    // bank state mirror
    logic signed [31:0] ph_cos [BINS];
    logic signed [31:0] ph_sin [BINS];
    logic signed [31:0] rot_cos [BINS];
    logic signed [31:0] rot_sin [BINS];
    logic signed [63:0] acc_re [(PORTS+1)*BINS];
    logic signed [63:0] acc_im [(PORTS+1)*BINS];
    logic [2:0]  reg_ports;
    logic [8:0]  reg_bins;
    logic [30:0] reg_scale;

    t_spectrum pending_spectra [$];
    int errors = 0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int recv_hold = 0;

    function automatic logic signed [63:0] rnd_q30(input logic signed [127:0] p);
        logic signed [127:0] t;
        t = (p + 128'sd536870912) >>> 30;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] d);
        logic signed [64:0] s;
        s = 65'(a) + 65'(d);
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void clear_bank();
        for (int m = 0; m < BINS; m++) begin
            ph_cos[m] = ONE_Q30;
            ph_sin[m] = '0;
        end
        for (int k = 0; k < (PORTS+1)*BINS; k++) begin
            acc_re[k] = '0;
            acc_im[k] = '0;
        end
    endfunction

    function automatic int eff_bins();
        return reg_bins > BINS ? BINS : reg_bins;
    endfunction

    function automatic int eff_ports();
        return reg_ports > PORTS ? PORTS : reg_ports;
    endfunction

    // apply one accepted item to the mirror; reads queue their spectrum
    function automatic void predict_spectrum(input t_item it);
        logic signed [127:0] smp, scl, c, s, rc, rs;
        logic signed [63:0] w;
        int k;
        t_spectrum r;
        case (it.op)
            OP_FOLD: begin
                scl = $signed({97'd0, reg_scale});
                for (int ch = 0; ch <= PORTS; ch++) begin
                    if (ch == SRC_CH || ch < eff_ports()) begin
                        smp = it.smp[ch == SRC_CH ? 4 : ch];
                        w = rnd_q30(smp * scl);
                        for (int m = 0; m < eff_bins(); m++) begin
                            k = ch * BINS + m;
                            c = ph_cos[m];
                            s = ph_sin[m];
                            acc_re[k] = acc_add(acc_re[k], rnd_q30(128'(w) * c));
                            acc_im[k] = acc_add(acc_im[k], -rnd_q30(128'(w) * s));
                        end
                    end
                end
                for (int m = 0; m < eff_bins(); m++) begin
                    c = ph_cos[m];
                    s = ph_sin[m];
                    rc = rot_cos[m];
                    rs = rot_sin[m];
                    ph_cos[m] = clip32(rnd_q30(c * rc - s * rs));
                    ph_sin[m] = clip32(rnd_q30(s * rc + c * rs));
                end
            end
            OP_READ: begin
                r.in_range = (it.chan == SRC_CH || it.chan < eff_ports())
                             && it.bin < eff_bins();
                r.re = r.in_range ? acc_re[it.chan * BINS + it.bin] : '0;
                r.im = r.in_range ? acc_im[it.chan * BINS + it.bin] : '0;
                pending_spectra = {pending_spectra, r};
            end
            OP_RESTART: clear_bank();
            default: begin
                rot_cos[it.bin] = it.rot_c;
                rot_sin[it.bin] = it.rot_s;
            end
        endcase
    endfunction

    task automatic send_item(input t_item it);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.op;
        i_s_axis_tdata  <= {5'd0, it.rot_s, it.rot_c, it.bin, it.chan,
                            it.smp[4], it.smp[3], it.smp[2], it.smp[1], it.smp[0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_spectrum(it);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
    endtask

    function automatic t_item blank_item(input logic [1:0] op);
        t_item it;
        it.op = op;
        for (int i = 0; i < 5; i++) it.smp[i] = '0;
        it.chan = 3'd4;
        it.bin = '0;
        it.rot_c = '0;
        it.rot_s = '0;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_rot();
        return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_read(input logic [2:0] ch, input logic [7:0] bin);
        t_item it;
        it = blank_item(OP_READ);
        it.chan = ch;
        it.bin = bin;
        send_item(it);
    endtask

    task automatic send_fold(input logic signed [31:0] v);
        t_item it;
        it = blank_item(OP_FOLD);
        for (int i = 0; i < 5; i++) it.smp[i] = v;
        send_item(it);
    endtask

    // a read is served only after everything before it, so its result marks idle
    task automatic wait_idle();
        send_read(3'd4, 8'd0);
        stop_sending();
        while (pending_spectra.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PORTS: reg_ports = val[2:0];
            CFG_BINS:  reg_bins  = val[8:0];
            CFG_SCALE: reg_scale = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [2:0] p, input logic [8:0] b,
                              input logic [30:0] s);
        wait_idle();
        write_reg(CFG_PORTS, 31'(p));
        write_reg(CFG_BINS, 31'(b));
        write_reg(CFG_SCALE, s);
        write_reg(CFG_NONE, 31'($urandom()));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(input bit allow_fold);
        t_item it;
        int pick;
        int top;
        pick = $urandom_range(99);
        it = blank_item(OP_READ);
        for (int i = 0; i < 5; i++) it.smp[i] = rand_sample();
        it.chan = 3'($urandom_range(7));
        it.rot_c = rand_rot();
        it.rot_s = rand_rot();
        top = eff_bins() > 254 ? 255 : eff_bins() + 1;
        it.bin = $urandom_range(4) == 0 ? 8'($urandom()) : 8'($urandom_range(top));
        if (pick < 45 && allow_fold) it.op = OP_FOLD;
        else if (pick < 48) it.op = OP_RESTART;
        else if (pick < 60) it.op = OP_LOAD;
        else it.op = OP_READ;
        send_item(it);
    endtask

    task automatic test_rotation_load();
        t_item it;
        it = blank_item(OP_LOAD);
        for (int m = 0; m < BINS; m++) begin
            it.bin = 8'(m);
            case (m)
                0: begin it.rot_c = ONE_Q30;       it.rot_s = '0;            end
                1: begin it.rot_c = -ONE_Q30;      it.rot_s = ONE_Q30;       end
                2: begin it.rot_c = '0;            it.rot_s = -ONE_Q30;      end
                3: begin it.rot_c = ONE_Q30;       it.rot_s = ONE_Q30;       end
                default: begin it.rot_c = rand_rot(); it.rot_s = rand_rot(); end
            endcase
            send_item(it);
        end
        stop_sending();
    endtask

    task automatic test_directed();
        set_config(3'd4, 9'd4, 31'h7FFF_FFFF);
        send_fold(32'sh7FFF_FFFF);
        send_fold(32'sh8000_0000);
        send_fold(32'sh0000_0001);
        for (int ch = 0; ch < 8; ch++) send_read(3'(ch), 8'd3);
        send_read(3'd0, 8'd4);          // bin past the active count
        send_read(3'd4, 8'd255);
        send_item(blank_item(OP_RESTART));
        send_read(3'd2, 8'd1);
        stop_sending();
        set_config(3'd2, 9'd0, 31'd0);  // no bins at all, zero weight
        send_fold(32'sh7FFF_FFFF);
        send_read(3'd1, 8'd0);
        send_read(3'd3, 8'd0);
        stop_sending();
    endtask

    task automatic test_config_extremes();
        set_config(3'd0, 9'd1, 31'd0);
        repeat (10) send_random(1'b1);
        set_config(3'd7, 9'd3, 31'h7FFF_FFFF);
        repeat (10) send_random(1'b1);
        set_config(3'd4, 9'd256, 31'h4000_0000);
        send_fold(rand_sample());
        send_fold(rand_sample());
        repeat (8) send_random(1'b0);
        set_config(3'd5, 9'd511, 31'($urandom()));
        send_fold(rand_sample());
        repeat (8) send_random(1'b0);
        stop_sending();
    endtask

    task automatic random_phase(input int sg, input int rg, input int n);
        send_gap_pct = sg;
        recv_gap_pct = rg;
        for (int i = 0; i < n; i++) begin
            if (i % 90 == 45) begin
                stop_sending();
                set_config(3'($urandom()), 9'($urandom_range(1, 16)), 31'($urandom()));
            end
            if (i == 120) begin
                // sender waits for every outstanding result
                stop_sending();
                while (pending_spectra.size() > 0) @(posedge i_clk);
            end
            send_random(1'b1);
        end
        stop_sending();
    endtask

    task automatic test_random();
        set_config(3'd4, 9'd12, 31'h4000_0000);
        random_phase(16, 47, 250);
        random_phase(47, 16, 250);
        random_phase(0, 0, 250);
    endtask

    task automatic test_output_stall();
        recv_hold = 600;
        for (int i = 0; i < 30; i++) begin
            if (i % 3 == 0) send_fold(rand_sample());
            else send_read(3'($urandom_range(4)), 8'($urandom_range(3)));
        end
        stop_sending();
    endtask

    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        t_spectrum e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_spectra.size() == 0) begin
                $error("unexpected result %h", o_m_axis_tdata);
                errors++;
            end else begin
                e = pending_spectra.pop_front();
                if ($signed(o_m_axis_tdata[63:0]) !== e.re) begin
                    $error("spectrum_real exp %0d got %0d", e.re,
                           $signed(o_m_axis_tdata[63:0]));
                    errors++;
                end
                if ($signed(o_m_axis_tdata[127:64]) !== e.im) begin
                    $error("spectrum_imag exp %0d got %0d", e.im,
                           $signed(o_m_axis_tdata[127:64]));
                    errors++;
                end
                if (o_m_axis_tuser[0] !== e.in_range) begin
                    $error("read_in_range exp %0d got %0d", e.in_range, o_m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_FOLD;
        i_m_axis_tready <= 1'b0;
        reg_ports = 3'd0;
        reg_bins  = 9'd200;
        reg_scale = 31'h4000_0000;
        clear_bank();
        for (int m = 0; m < BINS; m++) begin
            rot_cos[m] = '0;
            rot_sin[m] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rotation_load();
        test_directed();
        test_config_extremes();
        test_output_stall();
        test_random();
        while (pending_spectra.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
